@@ sv/titt_pkg.sv @@
// Shared types, constants and helpers for the timer table.
// Used by titt_cell and timeout_interval_timer_table; depends on nothing.
package titt_pkg;

    localparam int SLOTS  = 8;
    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam logic [31:0] ONESHOT_BASE   = 32'h8000_0000;
    localparam logic [31:0] ONESHOT_LIMIT  = 32'hffff_fff0;
    localparam logic [31:0] PERIODIC_BASE  = 32'h0000_0001;
    localparam logic [31:0] PERIODIC_LIMIT = 32'h7fff_fff0;

    typedef enum logic [2:0] {
        OP_ARM_ONESHOT  = 3'd0,
        OP_ARM_PERIODIC = 3'd1,
        OP_CLEAR_ID     = 3'd2,
        OP_CLEAR_ALL    = 3'd3,
        OP_REFRESH      = 3'd4
    } t_op;

    typedef enum logic [1:0] {
        KIND_ARM    = 2'd0,
        KIND_EXPIRE = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    // One command walking down the row of slot cells, one cell per cycle.
    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [31:0]       period;
        logic [31:0]       now;
        logic [31:0]       target;
        logic [31:0]       new_id;
        logic              placed;
        logic [SLOT_W-1:0] arm_slot;
        logic [SLOT_W-1:0] pos;
        logic              hit;
        logic [31:0]       hit_id;
        logic [SLOT_W-1:0] hit_pos;
    } t_token;

    // Next id from a counter, reloading to base once it is above its limit, before the increment.
    function automatic logic [31:0] next_id(input logic [31:0] cnt,
                                            input logic [31:0] limit,
                                            input logic [31:0] base);
        logic [31:0] v;
        v = (cnt > limit) ? base : cnt;
        return v + 32'd1;
    endfunction

endpackage

@@ sv/titt_cell.sv @@
// One timer slot of the table: id, start time and period, plus the token stage
// that hands the command to the next slot. Depends on titt_pkg.
module titt_cell import titt_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_token i_tok,
    output t_token o_tok
);

    logic [31:0] r_ident, n_ident;
    logic [31:0] r_start, n_start;
    logic [31:0] r_period, n_period;
    t_token      r_tok, n_tok;
    logic [31:0] w_elapsed;

    assign w_elapsed = i_tok.now - r_start;

    always_comb begin
        n_ident      = r_ident;
        n_start      = r_start;
        n_period     = r_period;
        n_tok        = i_tok;
        n_tok.pos    = i_tok.pos + SLOT_W'(1);
        n_tok.hit    = 1'b0;
        n_tok.hit_id = '0;
        n_tok.hit_pos = i_tok.pos;
        if (i_tok.valid) begin
            unique case (i_tok.op)
                OP_ARM_ONESHOT, OP_ARM_PERIODIC: begin
                    // take the first free slot on the way
                    if (!i_tok.placed && r_ident == 32'd0) begin
                        n_ident        = i_tok.new_id;
                        n_start        = i_tok.now;
                        n_period       = i_tok.period;
                        n_tok.placed   = 1'b1;
                        n_tok.arm_slot = i_tok.pos;
                    end
                end
                OP_CLEAR_ID: begin
                    if (i_tok.target != 32'd0 && r_ident == i_tok.target) begin
                        n_ident = '0;
                    end
                end
                OP_CLEAR_ALL: begin
                    n_ident = '0;
                end
                OP_REFRESH: begin
                    if (r_ident != 32'd0 && w_elapsed >= r_period) begin
                        n_tok.hit    = 1'b1;
                        n_tok.hit_id = r_ident;
                        // periodic restarts, one-shot frees the slot
                        if (r_ident[31]) begin
                            n_ident = '0;
                        end else begin
                            n_start = i_tok.now;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ident  <= '0;
            r_start  <= '0;
            r_period <= '0;
            r_tok    <= '0;
        end else begin
            r_ident  <= n_ident;
            r_start  <= n_start;
            r_period <= n_period;
            r_tok    <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

@@ sv/timeout_interval_timer_table.sv @@
// Timer table: one command at a time walks a row of SLOTS slot cells, one per cycle.
// The final result goes through head register, slot cells, finish and output registers;
// expiries show earlier, at most one per cycle, each the cycle after the next is found.
// A new item is accepted only once busy has fallen after the last one left the cell row.
// Reset (synchronous, active low) frees all slots and reloads both id counters.
// Results cannot be stalled: each o_strobe pulse is one result; o_last marks a final one.
module timeout_interval_timer_table import titt_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_period_us,
    input  logic [31:0] i_now_us,
    input  logic [31:0] i_target_id,
    output logic        o_strobe,
    output logic [1:0]  o_kind,
    output logic [31:0] o_timer_id,
    output logic [2:0]  o_slot_index,
    output logic        o_periodic,
    output logic        o_last
);

    t_token w_tok [SLOTS+1];
    logic [SLOTS:0] w_tok_v;

    t_token      r_head, n_head;
    t_token      r_end, n_end;
    logic        r_busy, n_busy;
    logic        r_fin, n_fin;
    logic [31:0] r_one_cnt, n_one_cnt;
    logic [31:0] r_per_cnt, n_per_cnt;
    logic        r_hold_v, n_hold_v;
    logic [31:0] r_hold_id, n_hold_id;
    logic [2:0]  r_hold_slot, n_hold_slot;

    logic        r_o_strobe, n_o_strobe;
    logic [1:0]  r_o_kind, n_o_kind;
    logic [31:0] r_o_id, n_o_id;
    logic [2:0]  r_o_slot, n_o_slot;
    logic        r_o_per, n_o_per;
    logic        r_o_last, n_o_last;

    logic        w_hit;
    logic [31:0] w_hit_id;
    logic [2:0]  w_hit_slot;
    logic        w_accept;
    t_op         w_op;

    assign w_tok[0] = r_head;
    assign w_accept = start && !r_busy;
    assign w_op     = t_op'(i_opcode);

    for (genvar k = 0; k < SLOTS; k++) begin : g_cell
        titt_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_tok[k]),
            .o_tok  (w_tok[k+1])
        );
    end

    always_comb begin
        for (int k = 0; k <= SLOTS; k++) begin
            w_tok_v[k] = w_tok[k].valid;
        end
    end

    // Only one cell holds the token, so OR the gated hit fields together.
    always_comb begin
        w_hit      = 1'b0;
        w_hit_id   = '0;
        w_hit_slot = '0;
        for (int k = 1; k <= SLOTS; k++) begin
            if (w_tok[k].valid && w_tok[k].hit) begin
                w_hit      = 1'b1;
                w_hit_id   = w_hit_id | w_tok[k].hit_id;
                w_hit_slot = w_hit_slot | 3'(w_tok[k].hit_pos);
            end
        end
    end

    always_comb begin
        n_head       = r_head;
        n_head.valid = 1'b0;
        n_end        = r_end;
        n_busy       = r_busy;
        n_fin        = 1'b0;
        n_one_cnt    = r_one_cnt;
        n_per_cnt    = r_per_cnt;
        n_hold_v     = r_hold_v;
        n_hold_id    = r_hold_id;
        n_hold_slot  = r_hold_slot;
        n_o_strobe   = 1'b0;
        n_o_kind     = r_o_kind;
        n_o_id       = r_o_id;
        n_o_slot     = r_o_slot;
        n_o_per      = r_o_per;
        n_o_last     = r_o_last;

        if (w_accept) begin
            n_busy          = 1'b1;
            n_head          = '0;
            n_head.valid    = 1'b1;
            n_head.op       = w_op;
            n_head.period   = i_period_us;
            n_head.now      = i_now_us;
            n_head.target   = i_target_id;
            n_head.new_id   = (w_op == OP_ARM_PERIODIC)
                            ? next_id(r_per_cnt, PERIODIC_LIMIT, PERIODIC_BASE)
                            : next_id(r_one_cnt, ONESHOT_LIMIT, ONESHOT_BASE);
        end

        if (r_fin) begin
            n_busy     = 1'b0;
            n_o_strobe = 1'b1;
            n_o_last   = 1'b1;
            if (r_end.op == OP_REFRESH && r_hold_v) begin
                n_o_kind = KIND_EXPIRE;
                n_o_id   = r_hold_id;
                n_o_slot = r_hold_slot;
                n_o_per  = ~r_hold_id[31];
                n_hold_v = 1'b0;
            end else if (r_end.op == OP_ARM_ONESHOT || r_end.op == OP_ARM_PERIODIC) begin
                n_o_kind = KIND_ARM;
                n_o_id   = r_end.placed ? r_end.new_id : 32'd0;
                n_o_slot = r_end.placed ? 3'(r_end.arm_slot) : 3'd0;
                n_o_per  = (r_end.op == OP_ARM_PERIODIC);
            end else begin
                n_o_kind = KIND_ACK;
                n_o_id   = '0;
                n_o_slot = '0;
                n_o_per  = 1'b0;
            end
        end else if (w_hit) begin
            // release the held expiry, it is not the last one
            if (r_hold_v) begin
                n_o_strobe = 1'b1;
                n_o_kind   = KIND_EXPIRE;
                n_o_id     = r_hold_id;
                n_o_slot   = r_hold_slot;
                n_o_per    = ~r_hold_id[31];
                n_o_last   = 1'b0;
            end
            n_hold_v    = 1'b1;
            n_hold_id   = w_hit_id;
            n_hold_slot = w_hit_slot;
        end

        if (w_tok[SLOTS].valid) begin
            n_fin = 1'b1;
            n_end = w_tok[SLOTS];
            if (w_tok[SLOTS].placed) begin
                if (w_tok[SLOTS].op == OP_ARM_PERIODIC) begin
                    n_per_cnt = w_tok[SLOTS].new_id;
                end else begin
                    n_one_cnt = w_tok[SLOTS].new_id;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_busy     <= 1'b0;
            r_fin      <= 1'b0;
            r_one_cnt  <= ONESHOT_BASE;
            r_per_cnt  <= PERIODIC_BASE;
            r_hold_v   <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_head     <= n_head;
            r_busy     <= n_busy;
            r_fin      <= n_fin;
            r_one_cnt  <= n_one_cnt;
            r_per_cnt  <= n_per_cnt;
            r_hold_v   <= n_hold_v;
            r_o_strobe <= n_o_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end       <= n_end;
        r_hold_id   <= n_hold_id;
        r_hold_slot <= n_hold_slot;
        r_o_kind    <= n_o_kind;
        r_o_id      <= n_o_id;
        r_o_slot    <= n_o_slot;
        r_o_per     <= n_o_per;
        r_o_last    <= n_o_last;
    end

    assign busy         = r_busy;
    assign o_strobe     = r_o_strobe;
    assign o_kind       = r_o_kind;
    assign o_timer_id   = r_o_id;
    assign o_slot_index = r_o_slot;
    assign o_periodic   = r_o_per;
    assign o_last       = r_o_last;

`ifndef SYNTHESIS
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one command in the slot row");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_last |-> !busy)
        else $error("final result while still busy");

    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last |-> busy)
        else $error("non-final result outside a transaction");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");
`endif

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for timeout_interval_timer_table: directed and random command traffic.
// Predicts every result from its own copy of the slot table; depends on titt_pkg.
module tb;
    import titt_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] id;
        logic [2:0]  slot;
        logic        periodic;
        logic        last;
    } t_timer_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_period_us = '0;
    logic [31:0] i_now_us = '0;
    logic [31:0] i_target_id = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [31:0] o_timer_id;
    logic [2:0]  o_slot_index;
    logic        o_periodic;
    logic        o_last;

    // Predicted table state
    logic [31:0] tbl_ident [SLOTS];
    logic [31:0] tbl_start [SLOTS];
    logic [31:0] tbl_period [SLOTS];
    logic [31:0] oneshot_ctr;
    logic [31:0] periodic_ctr;

    t_timer_result pending_results [$];
    int            error_count = 0;
    int            cycle_count = 0;
    bit            sender_calm = 1'b0;

    timeout_interval_timer_table DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_opcode     (i_opcode),
        .i_period_us  (i_period_us),
        .i_now_us     (i_now_us),
        .i_target_id  (i_target_id),
        .o_strobe     (o_strobe),
        .o_kind       (o_kind),
        .o_timer_id   (o_timer_id),
        .o_slot_index (o_slot_index),
        .o_periodic   (o_periodic),
        .o_last       (o_last)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic reset_timer_model();
        int s;
        for (s = 0; s < SLOTS; s++) begin
            tbl_ident[s]  = '0;
            tbl_start[s]  = '0;
            tbl_period[s] = '0;
        end
        oneshot_ctr  = ONESHOT_BASE;
        periodic_ctr = PERIODIC_BASE;
    endtask

    function automatic void predict_timer_results(logic [2:0] op, logic [31:0] per,
                                                  logic [31:0] now, logic [31:0] target);
        t_timer_result    r;
        int               s;
        int               free_slot;
        int               last_hit;
        logic [SLOTS-1:0] fires;
        r = '{KIND_ACK, 32'd0, 3'd0, 1'b0, 1'b1};
        case (op)
            OP_ARM_ONESHOT, OP_ARM_PERIODIC: begin
                r.kind = KIND_ARM;
                r.periodic = (op == OP_ARM_PERIODIC);
                free_slot = -1;
                for (s = SLOTS - 1; s >= 0; s--)
                    if (tbl_ident[s] == 0) free_slot = s;
                // full table: id 0 in slot 0, counters hold
                if (free_slot >= 0) begin
                    if (r.periodic) begin
                        if (periodic_ctr > PERIODIC_LIMIT) periodic_ctr = PERIODIC_BASE;
                        periodic_ctr = periodic_ctr + 1;
                        r.id = periodic_ctr;
                    end else begin
                        if (oneshot_ctr > ONESHOT_LIMIT) oneshot_ctr = ONESHOT_BASE;
                        oneshot_ctr = oneshot_ctr + 1;
                        r.id = oneshot_ctr;
                    end
                    tbl_ident[free_slot]  = r.id;
                    tbl_start[free_slot]  = now;
                    tbl_period[free_slot] = per;
                    r.slot = 3'(free_slot);
                end
                pending_results.push_back(r);
            end
            OP_CLEAR_ID: begin
                if (target != 0)
                    for (s = 0; s < SLOTS; s++)
                        if (tbl_ident[s] == target) tbl_ident[s] = '0;
                pending_results.push_back(r);
            end
            OP_CLEAR_ALL: begin
                for (s = 0; s < SLOTS; s++) tbl_ident[s] = '0;
                pending_results.push_back(r);
            end
            OP_REFRESH: begin
                last_hit = -1;
                for (s = 0; s < SLOTS; s++) begin
                    fires[s] = (tbl_ident[s] != 0) &&
                               (32'(now - tbl_start[s]) >= tbl_period[s]);
                    if (fires[s]) last_hit = s;
                end
                if (last_hit < 0) pending_results.push_back(r);
                for (s = 0; s < SLOTS; s++) begin
                    if (fires[s]) begin
                        r.kind     = KIND_EXPIRE;
                        r.id       = tbl_ident[s];
                        r.slot     = 3'(s);
                        r.periodic = ~tbl_ident[s][31];
                        r.last     = (s == last_hit);
                        // periodic slots restart, one-shot slots free up
                        if (r.periodic) tbl_start[s] = now;
                        else tbl_ident[s] = '0;
                        pending_results.push_back(r);
                    end
                end
            end
            default: pending_results.push_back(r);
        endcase
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_timer_result want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual kind %0d id %h",
                         $time, o_kind, o_timer_id);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("kind", 32'(want.kind), 32'(o_kind));
                check_field("timer_id", want.id, o_timer_id);
                check_field("slot_index", 32'(want.slot), 32'(o_slot_index));
                check_field("periodic", 32'(want.periodic), 32'(o_periodic));
                check_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Send one command; returns at the edge that accepts the transaction.
    task automatic send_cmd(logic [2:0] op, logic [31:0] per, logic [31:0] now,
                            logic [31:0] target);
        int gap;
        if (!sender_calm && $urandom_range(99) < 13) begin
            gap = $urandom_range(1, 2 * SLOTS + 4);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_opcode    <= op;
        i_period_us <= per;
        i_now_us    <= now;
        i_target_id <= target;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predict_timer_results(op, per, now, target);
    endtask

    // Hold off the sender until every outstanding result has arrived.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_arm_to_full();
        int k;
        send_cmd(OP_ARM_ONESHOT, 32'd0, 32'd0, 32'd0);
        send_cmd(OP_ARM_PERIODIC, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(OP_ARM_PERIODIC, 32'd5, 32'hffff_fffe, 32'd0);
        for (k = 3; k < SLOTS; k++)
            send_cmd(k[0] ? OP_ARM_PERIODIC : OP_ARM_ONESHOT, 32'd100, 32'h10, 32'd0);
        send_cmd(OP_ARM_ONESHOT, 32'd7, 32'd20, 32'd0);
        send_cmd(OP_ARM_PERIODIC, 32'd7, 32'd20, 32'd0);
        drain_results();
    endtask

    task automatic test_refresh_expiry();
        send_cmd(OP_REFRESH, 32'd0, 32'd3, 32'd0);
        send_cmd(OP_REFRESH, 32'd0, 32'd3, 32'd0);
        send_cmd(OP_REFRESH, 32'hffff_ffff, 32'd103, 32'hffff_ffff);
        send_cmd(OP_REFRESH, 32'd0, 32'hffff_ffff, 32'd0);
    endtask

    task automatic test_clear();
        send_cmd(OP_CLEAR_ID, 32'd0, 32'd0, 32'd0);
        send_cmd(OP_CLEAR_ID, 32'd0, 32'd0, tbl_ident[1]);
        send_cmd(OP_CLEAR_ID, 32'd0, 32'd0, 32'h1234_5678);
        send_cmd(OP_CLEAR_ALL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_cmd(OP_REFRESH, 32'd0, 32'h8000_0000, 32'd0);
    endtask

    task automatic test_unused_opcodes();
        int c;
        for (c = OP_REFRESH + 1; c < 8; c++)
            send_cmd(3'(c), $urandom, $urandom, $urandom);
    endtask

    // Mostly arm/refresh/clear against a running clock, with some noise.
    task automatic test_random_traffic(int count);
        logic [31:0] clock_us;
        logic [31:0] per;
        logic [31:0] tgt;
        int          n;
        int          pick;
        clock_us = $urandom;
        for (n = 0; n < count; n++) begin
            sender_calm = (n >= count / 3) && (n < count / 3 + 60);
            clock_us = clock_us + $urandom_range(0, 40);
            per = ($urandom_range(3) == 0) ? $urandom : $urandom_range(0, 60);
            pick = $urandom_range(99);
            if (pick < 30) begin
                send_cmd(OP_ARM_ONESHOT, per, clock_us, $urandom);
            end else if (pick < 50) begin
                send_cmd(OP_ARM_PERIODIC, per, clock_us, $urandom);
            end else if (pick < 78) begin
                send_cmd(OP_REFRESH, $urandom, clock_us, $urandom);
            end else if (pick < 88) begin
                tgt = ($urandom_range(3) == 0) ? $urandom
                                               : tbl_ident[$urandom_range(SLOTS - 1)];
                send_cmd(OP_CLEAR_ID, $urandom, clock_us, tgt);
            end else if (pick < 91) begin
                send_cmd(OP_CLEAR_ALL, $urandom, $urandom, $urandom);
            end else if (pick < 96) begin
                send_cmd(3'($urandom_range(7)), $urandom, $urandom, $urandom);
            end else begin
                // jump the clock anywhere in its range
                clock_us = $urandom;
                send_cmd(OP_REFRESH, $urandom, clock_us, $urandom);
            end
            if ($urandom_range(49) == 0) drain_results();
        end
        sender_calm = 1'b0;
    endtask

    initial begin
        reset_timer_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_arm_to_full();
        test_refresh_expiry();
        test_clear();
        test_unused_opcodes();
        test_random_traffic(RANDOM_ITEMS);
        drain_results();
        repeat (2 * SLOTS) @(posedge i_clk);
        if (error_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/titt_pkg.sv
sv/titt_cell.sv
sv/timeout_interval_timer_table.sv
verif/tb.sv
